// ----- design/ilist_pkg.sv -----
// Shared types and constants for the indexed list engine.
// Field widths, opcodes and status codes; no dependencies.
package ilist_pkg;

  localparam int OPCODE_W = 3;
  localparam int POS_W    = 10;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 9;

  typedef logic [OPCODE_W-1:0] opcode_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam opcode_t OP_GET      = 3'd0;
  localparam opcode_t OP_ADD_HEAD = 3'd1;
  localparam opcode_t OP_ADD_TAIL = 3'd2;
  localparam opcode_t OP_ADD_AT   = 3'd3;
  localparam opcode_t OP_DEL_AT   = 3'd4;

  localparam status_t ST_DONE = 2'd0;
  localparam status_t ST_MISS = 2'd1;
  localparam status_t ST_FULL = 2'd2;

endpackage

// ----- design/ilist_channels.sv -----
// Valid/ready channel interfaces for the indexed list engine.
// Depends on ilist_pkg for field widths and types.
interface ilist_cmd_if;
  import ilist_pkg::*;
  logic                     valid;
  logic                     ready;
  opcode_t                  opcode;
  logic signed [POS_W-1:0]  position;
  logic signed [DATA_W-1:0] item_value;
  modport source (output valid, output opcode, output position, output item_value,
                  input ready);
  modport sink (input valid, input opcode, input position, input item_value,
                output ready);
endinterface

interface ilist_rsp_if;
  import ilist_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] read_value;
  status_t                  status;
  logic [LEN_W-1:0]         length_now;
  modport source (output valid, output read_value, output status, output length_now,
                  input ready);
  modport sink (input valid, input read_value, input status, input length_now,
                output ready);
endinterface

// ----- design/indexed_list_engine.sv -----
// Indexed list engine top level: sequencer around a value RAM and a link RAM.
// Depends on ilist_pkg, ilist_channels (ilist_cmd_if, ilist_rsp_if) and ilist_ram.
//
//  channel | dir | fields                              | item accepted when
//  --------+-----+-------------------------------------+---------------------
//  cmd     | in  | opcode, position, item_value        | cmd.valid & cmd.ready
//  rsp     | out | read_value, status, length_now      | rsp.valid & rsp.ready
//
// One item at a time. The walk down the link RAM runs one link per cycle through its
// single read port. Reset clears only control registers; free slots come from a fill
// counter, no clearing pass. A finished result waits in the rsp register while the next
// item is taken; the sequencer stalls at the end of that next item until rsp drains.
module indexed_list_engine #(
  parameter int CAPACITY   = 256,
  parameter int VALUE_BITS = 32
) (
  input logic         clk,
  input logic         rst,
  ilist_cmd_if.sink   cmd,
  ilist_rsp_if.source rsp
);
  import ilist_pkg::*;

  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_POP      = 4'd1;
  localparam logic [3:0] S_POPW     = 4'd2;
  localparam logic [3:0] S_WALK     = 4'd3;
  localparam logic [3:0] S_RDL      = 4'd4;
  localparam logic [3:0] S_INS_HEAD = 4'd5;
  localparam logic [3:0] S_INS_A    = 4'd6;
  localparam logic [3:0] S_INS_B    = 4'd7;
  localparam logic [3:0] S_DEL_A    = 4'd8;
  localparam logic [3:0] S_DEL_B    = 4'd9;
  localparam logic [3:0] S_RDV      = 4'd10;
  localparam logic [3:0] S_RDVW     = 4'd11;
  localparam logic [3:0] S_FIN      = 4'd12;

  localparam logic [1:0] K_GET = 2'd0;
  localparam logic [1:0] K_INS = 2'd1;
  localparam logic [1:0] K_DEL = 2'd2;

  logic [3:0]            state;
  logic [1:0]            kind;
  logic                  k_zero;
  logic [SLOT_W-1:0]     head_slot;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      fresh;       // slots ever handed out
  logic [SLOT_W-1:0]     free_slot;   // top of freed-slot stack
  logic [SLOT_W-1:0]     pop_next;
  logic                  from_stack;
  logic [SLOT_W-1:0]     new_slot;
  logic [SLOT_W-1:0]     cur;
  logic [SLOT_W-1:0]     prev;
  logic                  pending;     // link read in flight, rdata is next slot
  logic [CNT_W-1:0]      steps;
  logic [VALUE_BITS-1:0] val;
  logic [DATA_W-1:0]     res_value;
  status_t               res_status;
  logic                  rsp_valid;
  logic [DATA_W-1:0]     rsp_value;
  status_t               rsp_status;
  logic [LEN_W-1:0]      rsp_length;

  logic                  link_re, link_we;
  logic [SLOT_W-1:0]     link_raddr, link_waddr, link_wdata, link_rdata;
  logic                  val_re, val_we;
  logic [SLOT_W-1:0]     val_raddr;
  logic [VALUE_BITS-1:0] val_rdata;
  logic [VALUE_BITS-1:0] in_val;
  logic [DATA_W-1:0]     rd_ext;

  logic                  accept;
  logic [SLOT_W-1:0]     cur_eff;
  logic [SLOT_W-1:0]     free_head;
  logic                  stack_empty;
  logic                  pos_neg;
  logic [CMP_W-1:0]      pos_ext;
  logic [CMP_W-1:0]      cnt_ext;
  logic                  pos_lt_cnt;
  logic                  pos_le_cnt;
  logic [CNT_W-1:0]      pos_k;
  logic                  full;
  logic                  ins_ok;
  logic [CNT_W-1:0]      ins_k;

  assign accept     = cmd.valid && cmd.ready;
  assign cmd.ready  = (state == S_IDLE);
  assign rsp.valid  = rsp_valid;
  assign rsp.read_value = rsp_value;
  assign rsp.status     = rsp_status;
  assign rsp.length_now = rsp_length;

  assign cur_eff     = pending ? link_rdata : cur;
  assign stack_empty = (count == fresh);
  assign free_head   = stack_empty ? fresh[SLOT_W-1:0] : free_slot;

  assign pos_neg    = cmd.position[POS_W-1];
  assign pos_ext    = {{(CMP_W-POS_W+1){1'b0}}, cmd.position[POS_W-2:0]};
  assign cnt_ext    = CMP_W'(count);
  assign pos_lt_cnt = !pos_neg && (pos_ext < cnt_ext);
  assign pos_le_cnt = !pos_neg && (pos_ext <= cnt_ext);
  assign pos_k      = pos_ext[CNT_W-1:0];
  assign full       = (count == CNT_W'(CAPACITY));

  generate
    if (VALUE_BITS > DATA_W) begin : g_wide
      assign in_val = {{(VALUE_BITS-DATA_W){cmd.item_value[DATA_W-1]}}, cmd.item_value};
      assign rd_ext = val_rdata[DATA_W-1:0];
    end else if (VALUE_BITS == DATA_W) begin : g_same
      assign in_val = cmd.item_value;
      assign rd_ext = val_rdata;
    end else begin : g_narrow
      assign in_val = cmd.item_value[VALUE_BITS-1:0];
      assign rd_ext = {{(DATA_W-VALUE_BITS){val_rdata[VALUE_BITS-1]}}, val_rdata};
    end
  endgenerate

  always_comb begin
    ins_ok = 1'b1;
    ins_k  = '0;
    case (cmd.opcode)
      OP_ADD_TAIL: ins_k = count;
      OP_ADD_AT: begin
        ins_ok = pos_neg || pos_le_cnt;
        ins_k  = pos_neg ? '0 : pos_k;
      end
      default: ins_k = '0;
    endcase
  end

  // memory access per state
  always_comb begin
    link_re    = 1'b0;
    link_raddr = cur;
    link_we    = 1'b0;
    link_waddr = new_slot;
    link_wdata = head_slot;
    val_re     = 1'b0;
    val_raddr  = cur;
    val_we     = 1'b0;
    case (state)
      S_POP: begin
        link_re    = 1'b1;
        link_raddr = free_slot;
      end
      S_WALK: begin
        link_re    = (steps != '0);
        link_raddr = cur_eff;
      end
      S_RDL: link_re = 1'b1;
      S_INS_HEAD: begin
        link_we = 1'b1;
        val_we  = 1'b1;
      end
      S_INS_A: begin
        link_we    = 1'b1;
        link_wdata = link_rdata;
      end
      S_INS_B: begin
        link_we    = 1'b1;
        link_waddr = cur;
        link_wdata = new_slot;
        val_we     = 1'b1;
      end
      S_DEL_A: begin
        link_we    = !k_zero;
        link_waddr = prev;
        link_wdata = link_rdata;
      end
      S_DEL_B: begin
        link_we    = 1'b1;
        link_waddr = cur;
        link_wdata = free_head;
      end
      S_RDV: val_re = 1'b1;
      default: link_re = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head_slot <= '0;
      count     <= '0;
      fresh     <= '0;
      free_slot <= '0;
      pending   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      // S_FIN reloads the rsp register itself
      if (rsp_valid && rsp.ready && (state != S_FIN)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            res_value  <= '1;
            val        <= in_val;
            new_slot   <= free_head;
            from_stack <= !stack_empty;
            cur        <= head_slot;
            prev       <= head_slot;
            pending    <= 1'b0;
            case (cmd.opcode)
              OP_GET: begin
                kind  <= K_GET;
                steps <= pos_k;
                if (pos_lt_cnt) begin
                  res_status <= ST_DONE;
                  state      <= S_WALK;
                end else begin
                  res_status <= ST_MISS;
                  state      <= S_FIN;
                end
              end
              OP_ADD_HEAD, OP_ADD_TAIL, OP_ADD_AT: begin
                kind   <= K_INS;
                k_zero <= (ins_k == '0);
                steps  <= ins_k - 1'b1;
                if (!ins_ok) begin
                  res_status <= ST_MISS;
                  state      <= S_FIN;
                end else if (full) begin
                  res_status <= ST_FULL;
                  state      <= S_FIN;
                end else begin
                  res_status <= ST_DONE;
                  if (!stack_empty) begin
                    state <= S_POP;
                  end else if (ins_k == '0) begin
                    state <= S_INS_HEAD;
                  end else begin
                    state <= S_WALK;
                  end
                end
              end
              OP_DEL_AT: begin
                kind   <= K_DEL;
                k_zero <= (pos_k == '0);
                steps  <= pos_k;
                if (pos_lt_cnt) begin
                  res_status <= ST_DONE;
                  state      <= S_WALK;
                end else begin
                  res_status <= ST_MISS;
                  state      <= S_FIN;
                end
              end
              default: begin
                res_status <= ST_DONE;
                state      <= S_FIN;
              end
            endcase
          end
        end
        S_POP: state <= S_POPW;
        S_POPW: begin
          pop_next <= link_rdata;
          state    <= k_zero ? S_INS_HEAD : S_WALK;
        end
        S_WALK: begin
          cur <= cur_eff;
          if (steps == '0) begin
            pending <= 1'b0;
            state   <= (kind == K_GET) ? S_RDV : S_RDL;
          end else begin
            prev    <= cur_eff;
            pending <= 1'b1;
            steps   <= steps - 1'b1;
          end
        end
        S_RDL: state <= (kind == K_INS) ? S_INS_A : S_DEL_A;
        S_INS_A: state <= S_INS_B;
        S_INS_HEAD, S_INS_B: begin
          if (state == S_INS_HEAD) begin
            head_slot <= new_slot;
          end
          if (from_stack) begin
            free_slot <= pop_next;
          end else begin
            fresh <= fresh + 1'b1;
          end
          count <= count + 1'b1;
          state <= S_FIN;
        end
        S_DEL_A: begin
          if (k_zero) begin
            head_slot <= link_rdata;
          end
          state <= S_DEL_B;
        end
        S_DEL_B: begin
          free_slot <= cur;
          count     <= count - 1'b1;
          state     <= S_FIN;
        end
        S_RDV: state <= S_RDVW;
        S_RDVW: begin
          res_value <= rd_ext;
          state     <= S_FIN;
        end
        S_FIN: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid  <= 1'b1;
            rsp_value  <= res_value;
            rsp_status <= res_status;
            rsp_length <= LEN_W'(count);
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  ilist_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_links (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .re    (link_re),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  ilist_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_values (
    .clk   (clk),
    .we    (val_we),
    .waddr (new_slot),
    .wdata (val),
    .re    (val_re),
    .raddr (val_raddr),
    .rdata (val_rdata)
  );

`ifndef SYNTH
  a_fill_order: assert property (@(posedge clk) disable iff (rst)
    (count <= fresh) && (fresh <= CNT_W'(CAPACITY)))
    else $error("element count above fill count or capacity");

  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) && !accept |=> (state == S_IDLE))
    else $error("sequencer left idle without an item");

  a_pending_walk: assert property (@(posedge clk) disable iff (rst)
    pending |-> (state == S_WALK))
    else $error("link read pending outside walk");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_INS_HEAD) || (state == S_INS_B) |=> count == CNT_W'($past(count) + 1'b1))
    else $error("insert did not grow the list by one");
`endif

endmodule

// ----- design/ilist_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ilist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
